[hdl/tgem_pkg.sv]
// Shared constants, codes and result type for the tile grid edge mask store.
`default_nettype none

package tgem_pkg;

    localparam int GRID_SIDE_DEF = 128;
    localparam int KEY_SLOTS_DEF = 64;

    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_OCCUPIED = 2'd1;
    localparam logic [1:0] ST_OOB      = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] DIR_RIGHT  = 2'd0;
    localparam logic [1:0] DIR_TOP    = 2'd1;
    localparam logic [1:0] DIR_LEFT   = 2'd2;
    localparam logic [1:0] DIR_BOTTOM = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic        present;
        logic [31:0] cell_key;
        logic [3:0]  edge_mask;
    } t_result;

endpackage

`default_nettype wire

[hdl/tgem_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tgem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hdl/tgem_seq.sv]
// Sequencer and shared address unit: clear, key search and neighbor linking.
`default_nettype none

module tgem_seq #(
    parameter int GRID_SIDE = tgem_pkg::GRID_SIDE_DEF,
    parameter int KEY_SLOTS = tgem_pkg::KEY_SLOTS_DEF,
    localparam int DEPTH = GRID_SIDE * GRID_SIDE,
    localparam int IW    = $clog2(DEPTH),
    localparam int SW    = $clog2(KEY_SLOTS + 1),
    localparam int KAW   = $clog2(KEY_SLOTS),
    localparam int CLW   = SW + 4
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire                     i_op,
    input  wire  [7:0]              i_x,
    input  wire  [7:0]              i_y,
    input  wire  [31:0]             i_key,
    output tgem_pkg::t_result       o_res,
    output logic                    o_res_valid,
    input  wire                     i_res_take,
    output logic                    o_grid_we,
    output logic [IW-1:0]           o_grid_waddr,
    output logic [CLW-1:0]          o_grid_wdata,
    output logic [IW-1:0]           o_grid_raddr,
    input  wire  [CLW-1:0]          i_grid_rdata,
    output logic                    o_key_we,
    output logic [KAW-1:0]          o_key_waddr,
    output logic [31:0]             o_key_wdata,
    output logic [KAW-1:0]          o_key_raddr,
    input  wire  [31:0]             i_key_rdata
);

    localparam int CW1 = $clog2(GRID_SIDE) + 1;
    localparam logic [31:0] GS32 = 32'(GRID_SIDE);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CEN_RD, S_CEN_CHK, S_KEY_RD, S_KEY_CHK,
        S_SRCH, S_NB_RD, S_NB_CHK, S_CEN_WR, S_DONE
    } t_state;

    t_state            r_state;
    logic [IW-1:0]     r_clr;
    logic [SW-1:0]     r_count;
    logic [SW-1:0]     r_i;
    logic [SW-1:0]     r_pidx;
    logic              r_pend;
    logic [1:0]        r_nb;
    logic              r_op;
    logic [CW1-1:0]    r_x;
    logic [CW1-1:0]    r_y;
    logic [31:0]       r_key;
    logic [SW-1:0]     r_slot;
    logic [3:0]        r_mask;
    logic [1:0]        r_status;
    tgem_pkg::t_result r_res;

    logic              nb_sel;
    logic [CW1-1:0]    nx;
    logic [CW1-1:0]    ny;
    logic              inb;
    logic [IW-1:0]     addr;
    logic [SW-1:0]     slot_m1;
    logic [SW-1:0]     cell_slot;
    logic [3:0]        own_bit;
    logic [3:0]        other_bit;
    logic              in_grid;

    assign nb_sel = (r_state == S_NB_RD) || (r_state == S_NB_CHK);

    always_comb begin
        nx = r_x;
        ny = r_y;
        if (nb_sel) begin
            case (r_nb)
                tgem_pkg::DIR_RIGHT:  nx = r_x + CW1'(1);
                tgem_pkg::DIR_TOP:    ny = r_y - CW1'(1);
                tgem_pkg::DIR_LEFT:   nx = r_x - CW1'(1);
                tgem_pkg::DIR_BOTTOM: ny = r_y + CW1'(1);
                default:              nx = r_x;
            endcase
        end
    end

    assign inb       = (32'(nx) < GS32) && (32'(ny) < GS32);
    assign addr      = IW'(32'(ny) * GS32 + 32'(nx));
    assign slot_m1   = r_slot - SW'(1);
    assign cell_slot = i_grid_rdata[CLW-1:4];
    assign own_bit   = 4'b0001 << r_nb;
    assign other_bit = 4'b0001 << (r_nb ^ 2'd2);
    assign in_grid   = ({24'd0, i_x} < GS32) && ({24'd0, i_y} < GS32);

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_comb begin
        o_grid_we    = 1'b0;
        o_grid_waddr = addr;
        o_grid_wdata = {r_slot, r_mask};
        o_grid_raddr = addr;
        case (r_state)
            S_CLEAR: begin
                o_grid_we    = 1'b1;
                o_grid_waddr = r_clr;
                o_grid_wdata = '0;
            end
            S_NB_CHK: begin
                o_grid_we    = (cell_slot == r_slot);
                o_grid_wdata = i_grid_rdata | CLW'(other_bit);
            end
            S_CEN_WR: begin
                o_grid_we = 1'b1;
            end
            default: begin
                o_grid_we = 1'b0;
            end
        endcase
    end

    assign o_key_raddr = (r_state == S_SRCH) ? r_i[KAW-1:0] : slot_m1[KAW-1:0];
    assign o_key_waddr = r_count[KAW-1:0];
    assign o_key_wdata = r_key;
    assign o_key_we    = (r_state == S_SRCH) && !(r_pend && (i_key_rdata == r_key))
                         && !(r_i < r_count) && (r_count < SW'(KEY_SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IW'(1);
                    if (r_clr == IW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op  <= i_op;
                        r_x   <= CW1'(i_x);
                        r_y   <= CW1'(i_y);
                        r_key <= i_key;
                        if (in_grid) begin
                            r_state <= S_CEN_RD;
                        end else begin
                            r_res   <= '{tgem_pkg::ST_OOB, 1'b0, 32'd0, 4'd0};
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CEN_RD: begin
                    r_state <= S_CEN_CHK;
                end
                S_CEN_CHK: begin
                    r_slot   <= cell_slot;
                    r_mask   <= i_grid_rdata[3:0];
                    r_status <= (r_op == tgem_pkg::OP_READ) ? tgem_pkg::ST_DONE
                                                            : tgem_pkg::ST_OCCUPIED;
                    if (cell_slot != '0) begin
                        r_state <= S_KEY_RD;
                    end else if (r_op == tgem_pkg::OP_READ) begin
                        r_res   <= '{tgem_pkg::ST_DONE, 1'b0, 32'd0, 4'd0};
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SRCH;
                    end
                end
                S_KEY_RD: begin
                    r_state <= S_KEY_CHK;
                end
                S_KEY_CHK: begin
                    r_res   <= '{r_status, 1'b1, i_key_rdata, r_mask};
                    r_state <= S_DONE;
                end
                S_SRCH: begin
                    r_mask <= '0;
                    r_nb   <= tgem_pkg::DIR_RIGHT;
                    if (r_pend && (i_key_rdata == r_key)) begin
                        r_slot  <= r_pidx + SW'(1);
                        r_pend  <= 1'b0;
                        r_state <= S_NB_RD;
                    end else if (r_i < r_count) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_i;
                        r_i    <= r_i + SW'(1);
                    end else begin
                        r_pend <= 1'b0;
                        if (r_count < SW'(KEY_SLOTS)) begin
                            r_count <= r_count + SW'(1);
                            r_slot  <= r_count + SW'(1);
                            r_state <= S_NB_RD;
                        end else begin
                            r_res   <= '{tgem_pkg::ST_FULL, 1'b0, 32'd0, 4'd0};
                            r_state <= S_DONE;
                        end
                    end
                end
                S_NB_RD: begin
                    if (inb) begin
                        r_state <= S_NB_CHK;
                    end else if (r_nb == tgem_pkg::DIR_BOTTOM) begin
                        r_state <= S_CEN_WR;
                    end else begin
                        r_nb <= r_nb + 2'd1;
                    end
                end
                S_NB_CHK: begin
                    if (cell_slot == r_slot) begin
                        r_mask <= r_mask | own_bit;
                    end
                    if (r_nb == tgem_pkg::DIR_BOTTOM) begin
                        r_state <= S_CEN_WR;
                    end else begin
                        r_nb    <= r_nb + 2'd1;
                        r_state <= S_NB_RD;
                    end
                end
                S_CEN_WR: begin
                    r_res   <= '{tgem_pkg::ST_DONE, 1'b1, r_key, r_mask};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/tile_grid_edge_mask_store.sv]
// Top level of the tile grid edge mask store: memories, sequencer, output register.
//
// Usage: one request stream in (s_axis), one result stream out (m_axis), one
// result per request. s_axis_tuser carries the operation (place or read),
// s_axis_tdata the column, row and environment key. m_axis_tuser carries the
// status, m_axis_tdata presence, stored key and neighbor edge mask.
// Each request runs through a small sequencer around one grid RAM and one key RAM:
// center read, key search (for a known key up to its match, or over all keys in use
// for a new key), up to four neighbor read/update pairs, center write and hand-off
// to the output register. A place at an occupied cell, a place with the key table
// full, a read (with or without the stored key lookup) and an out-of-bounds request
// stop earlier. The result reaches m_axis in the same cycle that s_axis_tready
// returns high.
// One request is in flight at a time; s_axis_tready is high only while idle.
// After reset the grid is cleared one cell per cycle, all GRID_SIDE*GRID_SIDE cells,
// with s_axis_tready low; the key table and its count restart empty.
// The output register holds a result while m_axis_tready is low; the next
// request is still accepted and its result waits in the sequencer.
`default_nettype none

module tile_grid_edge_mask_store #(
    parameter int GRID_SIDE = tgem_pkg::GRID_SIDE_DEF,
    parameter int KEY_SLOTS = tgem_pkg::KEY_SLOTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // tile_x[7:0], tile_y[15:8], env_key[47:16]
    input  wire  [0:0]  s_axis_tuser,   // operation[0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // present[0], cell_key[32:1], edge_mask[36:33]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int IW    = $clog2(DEPTH);
    localparam int SW    = $clog2(KEY_SLOTS + 1);
    localparam int KAW   = $clog2(KEY_SLOTS);
    localparam int CLW   = SW + 4;

    tgem_pkg::t_result seq_res;
    logic              seq_res_valid;
    logic              res_take;
    logic              grid_we;
    logic [IW-1:0]     grid_waddr;
    logic [CLW-1:0]    grid_wdata;
    logic [IW-1:0]     grid_raddr;
    logic [CLW-1:0]    grid_rdata;
    logic              key_we;
    logic [KAW-1:0]    key_waddr;
    logic [31:0]       key_wdata;
    logic [KAW-1:0]    key_raddr;
    logic [31:0]       key_rdata;
    logic              r_m_valid;
    tgem_pkg::t_result r_m_res;

    tgem_seq #(
        .GRID_SIDE (GRID_SIDE),
        .KEY_SLOTS (KEY_SLOTS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (s_axis_tuser[0]),
        .i_x          (s_axis_tdata[7:0]),
        .i_y          (s_axis_tdata[15:8]),
        .i_key        (s_axis_tdata[47:16]),
        .o_res        (seq_res),
        .o_res_valid  (seq_res_valid),
        .i_res_take   (res_take),
        .o_grid_we    (grid_we),
        .o_grid_waddr (grid_waddr),
        .o_grid_wdata (grid_wdata),
        .o_grid_raddr (grid_raddr),
        .i_grid_rdata (grid_rdata),
        .o_key_we     (key_we),
        .o_key_waddr  (key_waddr),
        .o_key_wdata  (key_wdata),
        .o_key_raddr  (key_raddr),
        .i_key_rdata  (key_rdata)
    );

    tgem_ram #(
        .WIDTH (CLW),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr (grid_waddr),
        .i_wdata (grid_wdata),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    tgem_ram #(
        .WIDTH (32),
        .DEPTH (KEY_SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    assign res_take = seq_res_valid && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_take) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_m_res <= seq_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'd0, r_m_res.edge_mask, r_m_res.cell_key, r_m_res.present};
    assign m_axis_tuser  = r_m_res.status;

endmodule

`default_nettype wire
